### rtl/core/skcu_pkg.sv
// Shared types and constants for the scalar Kalman cell update unit.
// No dependencies; every other file of the block but skcu_if imports this package.
package skcu_pkg;

  // Fixed-point constants: gain in Q1.16, variance in Q16.16
  localparam logic [16:0] GainOne  = 17'd65536;
  localparam logic [31:0] VarReset = 32'd6553600;

  // Quotient bits produced by the gain divider, one per step
  localparam int unsigned DivSteps = 17;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input beat
    logic sum_en;    // form sum, seed the divider
    logic div_step;  // one restoring division step
    logic mul_en;    // run both multiplies
    logic upd_en;    // commit new estimate
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gain_one;  // gain forced to 1.0, skip the divider
  } sts_t;

endpackage

### rtl/core/skcu_if.sv
// Handshake channel interfaces for the measurement and result beats.
// Depends on nothing; used by the top level of the cell update unit.
interface skcu_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] z_meas;
  logic        [31:0] noise_var;

  modport source (output valid, output z_meas, output noise_var, input ready);
  modport sink   (input valid, input z_meas, input noise_var, output ready);
endinterface

interface skcu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elevation_est;
  logic        [31:0] variance_est;

  modport source (output valid, output elevation_est, output variance_est, input ready);
  modport sink   (input valid, input elevation_est, input variance_est, output ready);
endinterface

### rtl/core/skcu_ctrl.sv
// Sequencer of the cell update: accept, sum, divide, multiply, commit.
// Depends on skcu_pkg; drives the datapath in skcu_dp.
module skcu_ctrl import skcu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [2:0] {
    StIdle,
    StSum,
    StDiv,
    StMul,
    StUpd
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Decode state into datapath commands and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSum;
        end
      end
      StSum: begin
        cmd_o.sum_en = 1'b1;
        cnt_d        = '0;
        state_d      = StDiv;
      end
      StDiv: begin
        if (sts_i.gain_one) begin
          state_d = StMul;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_d = StMul;
          end
        end
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StUpd;
      end
      StUpd: begin
        // Hold until the result register is free
        if (out_free) begin
          cmd_o.upd_en = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/skcu_dp.sv
// Datapath of the cell update: estimate registers, restoring gain divider,
// the two multipliers and the variance floor. Depends on skcu_pkg.
module skcu_dp import skcu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [15:0] z_meas_i,
  input  logic        [31:0] noise_var_i,
  input  logic               cfg_we_i,
  input  logic        [31:0] cfg_wdata_i,
  output logic signed [31:0] elevation_o,
  output logic        [31:0] variance_o
);

  // Estimate state and configuration
  logic        [31:0] elev_q, var_q, min_var_q;
  // Captured beat
  logic        [15:0] z_q;
  logic        [31:0] noise_q;
  // Divider
  logic        [32:0] sum_q, rem_q, rem_d;
  logic        [16:0] dlo_q, quo_q, quo_d;
  logic               gain_one_q;
  // Products, already scaled by 2^-16
  logic        [31:0] elev_step_q, var_step_q;

  logic        [32:0] sum_d;
  logic        [33:0] trial;
  logic        [33:0] trial_sub;
  logic signed [32:0] diff;
  logic signed [17:0] gain_s;
  logic signed [50:0] elev_prod;
  logic        [16:0] one_minus;
  logic        [48:0] var_prod;
  logic        [31:0] new_var;

  assign sts_o.gain_one = gain_one_q;
  assign elevation_o    = elev_q;
  assign variance_o     = var_q;

  assign sum_d = {1'b0, var_q} + {1'b0, noise_q};

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_q, dlo_q[16]};
  assign trial_sub = trial - {1'b0, sum_q};
  always_comb begin
    if (trial >= {1'b0, sum_q}) begin
      rem_d = trial_sub[32:0];
      quo_d = {quo_q[15:0], 1'b1};
    end else begin
      rem_d = trial[32:0];
      quo_d = {quo_q[15:0], 1'b0};
    end
  end

  // Gain times the difference, and one minus gain times the variance
  assign diff      = $signed({z_q[15], z_q, 16'h0000}) - $signed({elev_q[31], elev_q});
  assign gain_s    = $signed({1'b0, quo_q});
  assign elev_prod = gain_s * diff;
  assign one_minus = GainOne - quo_q;
  assign var_prod  = one_minus * var_q;

  // Raise the new variance to the floor
  assign new_var = (var_step_q < min_var_q) ? min_var_q : var_step_q;

  // Control-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elev_q     <= '0;
      var_q      <= VarReset;
      min_var_q  <= '0;
      gain_one_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_var_q <= cfg_wdata_i;
      end
      if (cmd_i.sum_en) begin
        gain_one_q <= (elev_q == '0) || (sum_d == '0);
      end
      if (cmd_i.upd_en) begin
        elev_q <= elev_q + elev_step_q;
        var_q  <= new_var;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      z_q     <= z_meas_i;
      noise_q <= noise_var_i;
    end
    if (cmd_i.sum_en) begin
      sum_q <= sum_d;
      rem_q <= {2'b00, var_q[31:1]};
      dlo_q <= {var_q[0], 16'h0000};
      if ((elev_q == '0) || (sum_d == '0)) begin
        quo_q <= GainOne;
      end else begin
        quo_q <= '0;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dlo_q <= {dlo_q[15:0], 1'b0};
    end
    if (cmd_i.mul_en) begin
      elev_step_q <= elev_prod[47:16];
      var_step_q  <= var_prod[47:16];
    end
  end

endmodule

### rtl/core/scalar_kalman_cell_update_unit.sv
// Scalar Kalman update of one terrain cell. An accepted measurement beat
// goes through sum, 17 restoring gain divider steps, multiply and commit;
// the divider is skipped when the gain is forced to 1.0. One item is in
// flight at a time; the next is taken the cycle after commit. Reset
// clears elevation to 0, variance to 100.0 and the variance floor to 0.
// Depends on skcu_pkg, skcu_if, skcu_ctrl, skcu_dp.
module scalar_kalman_cell_update_unit import skcu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  skcu_in_if.sink     in_i,
  skcu_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  skcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Arithmetic and estimate state
  skcu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .z_meas_i    (in_i.z_meas),
    .noise_var_i (in_i.noise_var),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elevation_o (out_o.elevation_est),
    .variance_o  (out_o.variance_est)
  );

endmodule

### verif/skcu_update_checker.sv
// Checker for the scalar Kalman cell update unit: watches both channels and the floor writes,
// predicts every result beat and compares it field by field.
// Depends on skcu_pkg and skcu_if.
module skcu_update_checker import skcu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  skcu_in_if          in_mon,
  skcu_out_if         out_mon,
  output int          fail_count_o,
  output int          pending_o,
  output int          meas_count_o,
  output int          result_count_o
);

  typedef struct packed {
    logic signed [31:0] elevation;
    logic        [31:0] variance;
  } cell_est_t;

  // Cell state and variance floor of the prediction
  logic signed [31:0] cell_elev;
  logic        [31:0] cell_var;
  logic        [31:0] var_floor;
  cell_est_t          est_q[$];

  // Fuse one measurement into the cell and return the updated estimate
  function automatic cell_est_t kalman_fuse(input logic signed [15:0] z,
                                            input logic [31:0] noise);
    longint    sum;
    longint    gain;
    longint    diff;
    longint    step;
    longint    nvar;
    cell_est_t est;
    sum = longint'({32'd0, cell_var}) + longint'({32'd0, noise});
    // Unobserved cell or zero sum forces the gain to 1.0
    if (cell_elev == '0 || sum == 0) begin
      gain = longint'(GainOne);
    end else begin
      gain = longint'({16'd0, cell_var, 16'd0}) / sum;
    end
    if (gain > longint'(GainOne)) begin
      gain = longint'(GainOne);
    end
    // Step toward the measurement, rounding toward minus infinity
    diff = longint'(z) * longint'(GainOne) - longint'(cell_elev);
    step = (gain * diff) >>> 16;
    cell_elev = cell_elev + step[31:0];
    // Shrink the variance, then raise it to the floor
    nvar = ((longint'(GainOne) - gain) * longint'({32'd0, cell_var})) >>> 16;
    if (nvar < longint'({32'd0, var_floor})) begin
      nvar = longint'({32'd0, var_floor});
    end
    cell_var = nvar[31:0];
    est.elevation = cell_elev;
    est.variance  = cell_var;
    return est;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    fail_count_o++;
  endtask

  // Track floor writes, predict on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    cell_est_t want;
    if (!rst_ni) begin
      cell_elev      = '0;
      cell_var       = VarReset;
      var_floor      = '0;
      est_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      meas_count_o   = 0;
      result_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        var_floor = cfg_wdata_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        est_q.push_back(kalman_fuse(in_mon.z_meas, in_mon.noise_var));
        meas_count_o++;
      end
      if (out_mon.valid && out_mon.ready) begin
        result_count_o++;
        if (est_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", '0, out_mon.elevation_est);
        end else begin
          want = est_q.pop_front();
          if (out_mon.elevation_est !== want.elevation) begin
            report_mismatch("elevation_est", want.elevation, out_mon.elevation_est);
          end
          if (out_mon.variance_est !== want.variance) begin
            report_mismatch("variance_est", want.variance, out_mon.variance_est);
          end
        end
      end
      pending_o = est_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top for the scalar Kalman cell update unit: clock, reset, measurement
// stimulus, result back-pressure, floor writes and the verdict.
// Depends on skcu_pkg, skcu_if, scalar_kalman_cell_update_unit and skcu_update_checker.
module tb_top import skcu_pkg::*; ();

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned RandPhases   = 6;
  localparam int unsigned PhaseItems   = 125;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          meas_count;
  int          result_count;
  int unsigned cycles;
  int unsigned floor_writes;
  int unsigned stall_left;
  bit          idle_on;

  skcu_in_if  in_ch ();
  skcu_out_if out_ch ();

  scalar_kalman_cell_update_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  skcu_update_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .meas_count_o   (meas_count),
    .result_count_o (result_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result channel in random bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Send one measurement beat, at random with a gap in front of it while idling is enabled
  task automatic send_meas(input logic signed [15:0] z, input logic [31:0] noise);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.z_meas    <= z;
    in_ch.noise_var <= noise;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_floor(input logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    floor_writes++;
  endtask

  function automatic logic signed [15:0] pick_z();
    case ($urandom_range(0, 5))
      0:       return 16'sd0;
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2:       return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2, 3:    return $urandom_range(0, 32'h0004_0000);
      4:       return $urandom_range(0, 32'h1000_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_floor(input int unsigned phase);
    case (phase % 3)
      0:       return 32'd0;
      1:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n           = 1'b0;
    floor_writes    = 0;
    idle_on         = 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.z_meas    <= '0;
    in_ch.noise_var <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unobserved cell at reset, then zero variance with zero and nonzero noise
    send_meas(16'sd0, 32'd0);
    send_meas(16'sh8000, 32'hffff_ffff);
    send_meas(16'sh7fff, 32'd0);
    send_meas(16'sd100, 32'd5);

    // Top floor: variance pinned at full scale, zero noise gives unit gain
    write_floor(32'hffff_ffff);
    send_meas(-16'sd1, 32'd0);
    send_meas(16'sh7fff, 32'hffff_ffff);
    send_meas(16'sh8000, 32'd1);
    send_meas(16'sd0, 32'd0);
    send_meas(16'sd1, 32'h8000_0000);
    send_meas(16'sh5555, 32'haaaa_aaaa);

    // Floor of 1.0 with alternating bit patterns
    write_floor(32'h0001_0000);
    send_meas(16'shaaaa, 32'h5555_5555);
    send_meas(16'sh5555, 32'h0000_0001);
    send_meas(-16'sd2, 32'h0001_0000);
    send_meas(16'sd3, 32'h7fff_ffff);
    send_meas(16'sh7fff, 32'h0000_8000);

    // Random phases, each under its own floor; the last one runs without idling
    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      write_floor(pick_floor(phase));
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        idle_on = (phase != RandPhases - 1) && ((n / 30) % 3 != 2);
        send_meas(pick_z(), pick_noise());
      end
    end
    drain();

    $display("Covered %0d measurement beats and %0d result beats under %0d floor settings,",
             meas_count, result_count, floor_writes + 1);
    $display("including unobserved cells, zero sums, zero noise and full-scale floors.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### scalar_kalman_cell_update_unit.f
rtl/core/skcu_pkg.sv
rtl/core/skcu_if.sv
rtl/core/skcu_ctrl.sv
rtl/core/skcu_dp.sv
rtl/core/scalar_kalman_cell_update_unit.sv
verif/skcu_update_checker.sv
verif/tb_top.sv
